>>> rtl/sha256_stream_hasher_top_assert.svh
// assertion macros for the stream hasher
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// property that must hold at every edge outside reset
`define SHS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SHS_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/shs_pkg.sv
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } shs_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shs_out_t;

  // item classification handed from front to back
  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_BYTE_LAST = 2'd1,
    OP_LAST      = 2'd2
  } shs_op_e;

  typedef struct packed {
    shs_op_e    op;
    logic [7:0] data_byte;
  } shs_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ROUND   = 3'd1,
    ST_ADD     = 3'd2,
    ST_PAD     = 3'd3,
    ST_EMIT    = 3'd4
  } shs_state_e;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenPos   = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/shs_front.sv
module shs_front
  import shs_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  shs_in_t  in_i,
  output logic     cmd_valid_o,
  output shs_cmd_t cmd_o,
  input  logic     cmd_take_i
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  shs_cmd_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;
  logic keep, wr_en, rd_en;
  shs_cmd_t cmd;

  // idle items carry nothing and are dropped here
  assign keep  = in_i.has_byte | in_i.last;
  assign wr_en = push_i & ~full_o & keep;
  assign rd_en = cmd_take_i & cmd_valid_o;
  assign full_o = (cnt_q == (Aw+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = mem_q[rd_q];

  always_comb begin
    cmd.data_byte = in_i.data_byte;
    if (in_i.has_byte && in_i.last) begin
      cmd.op = OP_BYTE_LAST;
    end else if (in_i.has_byte) begin
      cmd.op = OP_BYTE;
    end else begin
      cmd.op = OP_LAST;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
    end
  end
endmodule

>>> rtl/shs_core.sv
module shs_core
  import shs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  shs_cmd_t cmd_i,
  output logic     cmd_take_o,
  output logic     empty_o,
  input  logic     pop_i,
  output shs_out_t out_o
);
  shs_state_e state_q, state_d;
  logic [31:0] chain_q [8];
  logic [31:0] blk_q [16];
  logic [31:0] wrk_q [8];
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic [2:0]  widx_q;
  logic        pad_q;   // set once the closing command is taken; cleared when the digest is popped
  logic        fin_q;   // compression in flight is the closing one

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [31:0] w, s0, s1, wnew, t1, t2, a, e;
  logic        start_cmp, do_take, take_last;

  assign pos = bits_q[8:3];
  assign wi  = pos[5:2];
  assign sh  = {~pos[1:0], 3'b000};

  // message schedule kept in place: blk_q shifts one word per round
  assign s0   = rotr(blk_q[1], 7) ^ rotr(blk_q[1], 18) ^ (blk_q[1] >> 3);
  assign s1   = rotr(blk_q[14], 17) ^ rotr(blk_q[14], 19) ^ (blk_q[14] >> 10);
  assign wnew = blk_q[0] + s0 + blk_q[9] + s1;
  assign w    = blk_q[0];
  assign a = wrk_q[0];
  assign e = wrk_q[4];
  assign t1 = wrk_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & wrk_q[5]) ^ (~e & wrk_q[6])) + RoundK[rnd_q] + w;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & wrk_q[1]) ^ (a & wrk_q[2]) ^ (wrk_q[1] & wrk_q[2]));

  assign empty_o = (state_q != ST_EMIT);
  assign out_o.digest_word = chain_q[widx_q];
  assign out_o.word_index  = widx_q;
  assign out_o.last_word   = (widx_q == 3'd7);

  always_comb begin
    state_d    = state_q;
    cmd_take_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          if (cmd_i.op == OP_BYTE && pos == 6'd63) begin
            state_d = ST_ROUND;
          end else if (cmd_i.op != OP_BYTE) begin
            state_d = (cmd_i.op == OP_BYTE_LAST && pos == 6'd63) ? ST_ROUND : ST_PAD;
          end
        end
      end
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:   state_d = fin_q ? ST_EMIT : (pad_q ? ST_PAD : ST_IDLE);
      ST_PAD:   state_d = ST_ROUND;
      ST_EMIT:  if (pop_i && widx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign do_take   = cmd_take_o;
  assign take_last = do_take && (cmd_i.op != OP_BYTE);
  assign start_cmp = (state_q != ST_ROUND) && (state_d == ST_ROUND);

  always_ff @(posedge clk_i) begin
    if (do_take && cmd_i.op != OP_LAST) begin
      blk_q[wi] <= ((pos[1:0] == 2'b00) ? 32'h0 : blk_q[wi])
                   | ({24'h0, cmd_i.data_byte} << sh);
    end
    if (state_q == ST_PAD) begin
      if (pad_q && fin_q) begin
        // second pass of a two-block pad: only the length
        for (int i = 0; i < 14; i++) blk_q[i] <= 32'h0;
        blk_q[14] <= bits_q[63:32];
        blk_q[15] <= bits_q[31:0];
      end else begin
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > wi) blk_q[i] <= 32'h0;
        end
        blk_q[wi] <= ((pos[1:0] == 2'b00) ? 32'h0 : blk_q[wi])
                     | ({24'h0, PadByte} << sh);
        if (pos < LenPos) begin
          blk_q[14] <= bits_q[63:32];
          blk_q[15] <= bits_q[31:0];
        end
      end
    end
    if (start_cmp) begin
      for (int i = 0; i < 8; i++) wrk_q[i] <= chain_q[i];
    end
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
      blk_q[15] <= wnew;
      wrk_q[7] <= wrk_q[6];
      wrk_q[6] <= wrk_q[5];
      wrk_q[5] <= wrk_q[4];
      wrk_q[4] <= wrk_q[3] + t1;
      wrk_q[3] <= wrk_q[2];
      wrk_q[2] <= wrk_q[1];
      wrk_q[1] <= wrk_q[0];
      wrk_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bits_q  <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
      pad_q   <= 1'b0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) chain_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      if (do_take && cmd_i.op != OP_LAST) bits_q <= bits_q + 64'd8;
      if (take_last) begin
        pad_q <= 1'b1;
      end
      if (state_q == ST_PAD) begin
        // pad byte placed; final compression unless length spills over
        if (!(pad_q && fin_q)) begin
          fin_q <= (pos < LenPos);
        end
        if (pad_q && fin_q) fin_q <= 1'b1;
      end
      // length block follows only when the pad byte already went out;
      // a message closing on a full block still needs its pad byte
      if (state_q == ST_ADD && pad_q && !fin_q && pos >= LenPos) begin
        fin_q <= 1'b1;
      end
      if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wrk_q[i];
      end
      if (state_q == ST_EMIT && pop_i) begin
        widx_q <= widx_q + 3'd1;
        if (widx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) chain_q[i] <= InitHash[i];
          bits_q <= '0;
          pad_q  <= 1'b0;
          fin_q  <= 1'b0;
        end
      end
    end
  end
endmodule

>>> rtl/sha256_stream_hasher_top.sv
// sha256 stream hasher
// input queue: push/full, one message byte per transaction with has_byte
// and last flags; a transaction with last set closes the message (it may
// also carry the final byte, or carry none); idle transactions are dropped
// result queue: empty/pop, eight 32-bit digest words, index 0 first,
// last_word set on the eighth
// a four-entry command queue sits between intake and the compression unit,
// so bytes can still be accepted while a block is compressed, until the queue fills
// the core takes one queued byte per cycle while idle; the 64th byte of a block
// starts a compression (the rounds, one per cycle, then the chaining add)
// closing a message costs a pad step and a compression, or two of each when
// the length spills into an extra block; a message that closes on a full
// block compresses that block first, then pads and compresses once more
// the eight words then wait for pop, one word per accepted transaction
// while the receiver stalls the digest holds, the core takes no commands,
// the queue fills and full rises
// reset restores the initial hash values, clears the length count and
// empties both queues
module sha256_stream_hasher_top
  import shs_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  shs_in_t  in_i,
  output logic     empty,
  input  logic     pop,
  output shs_out_t out_o
);
  `include "sha256_stream_hasher_top_assert.svh"

  logic     cmd_valid, cmd_take;
  shs_cmd_t cmd;

  shs_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .in_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  shs_core u_core (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .empty_o(empty), .pop_i(pop), .out_o
  );

  // the core only takes a command that the queue offers
  `SHS_NEVER(a_take_valid, clk_i, rst_ni, cmd_take && !cmd_valid, "take without command")
  // the last digest word ends the result burst
  `SHS_ASSERT(a_burst_end, clk_i, rst_ni, (pop && !empty && out_o.last_word) |=> empty, "burst continues")
  // an unpopped word holds
  `SHS_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_o)), "result changed")
endmodule

>>> test/sha256_stream_hasher_top_tb.sv
module sha256_stream_hasher_top_tb
  import shs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;

  // digest model: running sha-256 over the byte stream, expected words queued
  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [63:0] bit_count;
    shs_out_t    pending_words[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
      bit_count = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
             + RoundK[t] + w[t];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void place(int pos, logic [7:0] v);
      int sh;
      sh = (3 - pos % 4) * 8;
      if (pos % 4 == 0) blk[pos / 4] = '0;
      blk[pos / 4] |= 32'(v) << sh;
    endfunction

    // one accepted input transaction
    function void note_input(shs_in_t it);
      int pos;
      shs_out_t o;
      if (it.has_byte) begin
        pos = int'(bit_count[8:3]);
        place(pos, it.data_byte);
        bit_count += 64'd8;
        if (pos == 63) compress();
      end
      if (!it.last) return;
      pos = int'(bit_count[8:3]);
      place(pos, PadByte);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bit_count[63:32];
      blk[15] = bit_count[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        pending_words = {pending_words, o};
      end
      restart();
    endfunction

    function void check_result(shs_out_t got);
      shs_out_t exp;
      if (pending_words.size() == 0) begin
        $error("unexpected digest word %h", got.digest_word);
        errors++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.digest_word !== exp.digest_word) begin
        $error("digest_word exp %h got %h", exp.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== exp.word_index) begin
        $error("word_index exp %0d got %0d", exp.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== exp.last_word) begin
        $error("last_word exp %0d got %0d", exp.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  shs_in_t  in_i = '0;
  logic     empty;
  logic     pop = 1'b0;
  shs_out_t out_o;

  digest_scoreboard sb = new();
  bit  no_idle = 1'b0;    // long stretch with both sides busy
  bit  hold_pop = 1'b0;   // receiver hold-off to back the block up
  int  quiet_cycles = 0;

  sha256_stream_hasher_top dut (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // send one transaction; push stays high across back-to-back items
  task automatic send(logic [7:0] b, logic hb, logic lst);
    shs_in_t it;
    it.data_byte = b;
    it.has_byte = hb;
    it.last = lst;
    if (!no_idle) begin
      while ($urandom_range(99) < 8) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
  endtask

  task automatic send_message(int len, bit fold_last);
    for (int i = 0; i < len; i++)
      send(8'($urandom), 1'b1, fold_last && i == len - 1);
    if (!fold_last || len == 0) send(8'($urandom), 1'b0, 1'b1);
  endtask

  // result side: sample at the edge, check accepted words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(out_o);
      pop <= !hold_pop && (no_idle || $urandom_range(99) >= 8);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, idle items with stray bytes, padding boundaries
    send(8'hff, 1'b0, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b0);
    send(8'ha5, 1'b0, 1'b0);
    send(8'hff, 1'b0, 1'b1);
    send_message(3, 1'b1);
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(64, 1'b1);

    // receiver holds off while the sender keeps offering messages
    hold_pop = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_pop = 1'b0;
      end
      for (int m = 0; m < 4; m++) send_message($urandom_range(1, 6), $urandom_range(1));
    join

    // random messages, mostly short, with stray idle items mixed in
    n = 0;
    while (n < 80) begin
      int len;
      if ($urandom_range(9) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 12);
      if (n >= 10 && n < 70) no_idle = 1'b1;
      else no_idle = 1'b0;
      if ($urandom_range(5) == 0) send(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(1));
      n += len + 1;
    end
    no_idle = 1'b0;
    push <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
